FILE: hw/rtl/rti_pkg.sv
// Shared types, constants and saturating helpers for the ray/triangle intersection core.
package rti_pkg;

  // Intermediate values are held at 64 bits and saturate there.
  localparam int WORD_BITS = 64;
  typedef logic signed [WORD_BITS-1:0] sword_t;

  localparam sword_t SWORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam sword_t SWORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Pipeline depth of the fixed point multiplier and of the divider.
  localparam int MUL_LAT = 3;
  localparam int DIV_LAT = WORD_BITS + 2;

  typedef struct packed {
    sword_t x;
    sword_t y;
    sword_t z;
  } vec3_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_EPS   = 3'd6
  } cfg_reg_t;

  // Add with saturation at 64 bits.
  function automatic sword_t sat_add(sword_t a, sword_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? SWORD_MIN : SWORD_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

  // Subtract with saturation at 64 bits.
  function automatic sword_t sat_sub(sword_t a, sword_t b);
    logic signed [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      return s[WORD_BITS] ? SWORD_MIN : SWORD_MAX;
    end
    return s[WORD_BITS-1:0];
  endfunction

endpackage

FILE: hw/rtl/rti_mul.sv
// Pipelined signed fixed point multiplier: exact product, floor rescale, 64-bit saturation.
module rti_mul #(
  parameter int FRAC_BITS = 16
) (
  input  logic           clk,
  input  logic           en,
  input  rti_pkg::sword_t a,
  input  rti_pkg::sword_t b,
  output rti_pkg::sword_t p
);
  import rti_pkg::*;

  localparam int HALF = WORD_BITS / 2;
  localparam int PROD_BITS = 2 * WORD_BITS;
  localparam logic [PROD_BITS-1:0] RND = (PROD_BITS'(1) << FRAC_BITS) - PROD_BITS'(1);

  logic [WORD_BITS-1:0] ua;
  logic [WORD_BITS-1:0] ub;
  logic [WORD_BITS-1:0] p00;
  logic [WORD_BITS-1:0] p01;
  logic [WORD_BITS-1:0] p10;
  logic [WORD_BITS-1:0] p11;
  logic                 neg1;
  logic [PROD_BITS-1:0] prod;
  logic                 neg2;
  logic [WORD_BITS-1:0] low;
  logic                 high_nz;

  // Magnitudes of the operands.
  assign ua = a[WORD_BITS-1] ? WORD_BITS'(-a) : WORD_BITS'(a);
  assign ub = b[WORD_BITS-1] ? WORD_BITS'(-b) : WORD_BITS'(b);

  // First stage: four half-width partial products.
  always_ff @(posedge clk) begin
    if (en) begin
      neg1 <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
      p00  <= ua[HALF-1:0] * ub[HALF-1:0];
      p01  <= ua[HALF-1:0] * ub[WORD_BITS-1:HALF];
      p10  <= ua[WORD_BITS-1:HALF] * ub[HALF-1:0];
      p11  <= ua[WORD_BITS-1:HALF] * ub[WORD_BITS-1:HALF];
    end
  end

  // Second stage: full product, biased so that the shift rounds toward minus infinity.
  always_ff @(posedge clk) begin
    if (en) begin
      neg2 <= neg1;
      prod <= PROD_BITS'(p00)
            + (PROD_BITS'(p01) << HALF)
            + (PROD_BITS'(p10) << HALF)
            + {p11, {WORD_BITS{1'b0}}}
            + (neg1 ? RND : '0);
    end
  end

  // Third stage: rescale, saturate and restore the sign.
  assign low     = prod[FRAC_BITS +: WORD_BITS];
  assign high_nz = |prod[PROD_BITS-1 -: (WORD_BITS - FRAC_BITS)];

  always_ff @(posedge clk) begin
    if (en) begin
      if (high_nz || low[WORD_BITS-1]) begin
        p <= neg2 ? SWORD_MIN : SWORD_MAX;
      end else begin
        p <= neg2 ? -sword_t'(low) : sword_t'(low);
      end
    end
  end

endmodule

FILE: hw/rtl/rti_div.sv
// Pipelined restoring divider: signed 64-bit quotient truncated toward zero, saturated.
module rti_div (
  input  logic           clk,
  input  logic           en,
  input  rti_pkg::sword_t n,
  input  rti_pkg::sword_t d,
  output rti_pkg::sword_t q
);
  import rti_pkg::*;

  localparam int STEPS = WORD_BITS;

  logic [WORD_BITS-1:0] num  [0:STEPS];
  logic [WORD_BITS-1:0] den  [0:STEPS];
  logic [WORD_BITS-1:0] rem  [0:STEPS];
  logic [WORD_BITS-1:0] quo  [0:STEPS];
  logic                 neg  [0:STEPS];
  logic [WORD_BITS-1:0] part [1:STEPS];
  logic                 ge   [1:STEPS];

  // Set-up stage: magnitudes and sign of the quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      num[0] <= n[WORD_BITS-1] ? WORD_BITS'(-n) : WORD_BITS'(n);
      den[0] <= d[WORD_BITS-1] ? WORD_BITS'(-d) : WORD_BITS'(d);
      rem[0] <= '0;
      quo[0] <= '0;
      neg[0] <= n[WORD_BITS-1] ^ d[WORD_BITS-1];
    end
  end

  // Trial subtraction for each quotient bit, most significant first.
  always_comb begin
    for (int i = 1; i <= STEPS; i++) begin
      part[i] = {rem[i-1][WORD_BITS-2:0], num[i-1][WORD_BITS-1]};
      ge[i]   = part[i] >= den[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 1; i <= STEPS; i++) begin
        rem[i] <= ge[i] ? part[i] - den[i-1] : part[i];
        quo[i] <= {quo[i-1][WORD_BITS-2:0], ge[i]};
        num[i] <= {num[i-1][WORD_BITS-2:0], 1'b0};
        den[i] <= den[i-1];
        neg[i] <= neg[i-1];
      end
    end
  end

  // Sign and saturation of the final quotient.
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg[STEPS]) begin
        q <= quo[STEPS][WORD_BITS-1] ? SWORD_MIN : -sword_t'(quo[STEPS]);
      end else begin
        q <= quo[STEPS][WORD_BITS-1] ? SWORD_MAX : sword_t'(quo[STEPS]);
      end
    end
  end

endmodule

FILE: hw/rtl/ray_triangle_intersect_core.sv
// Top level of the ray/triangle intersection core.
// One ray (origin and direction, written through the configuration port) is tested
// against a stream of triangles with the Moller-Trumbore method in signed fixed point.
// The datapath is a single pipeline with multipliers split into half-width partial
// products and one fully unrolled restoring divider per quotient (u, v and t), so a
// new triangle is taken in every cycle unless the pipeline stalls, and each result passes
// through three multiplier passes, the divider and the add and compare stages between
// them. A two-entry output buffer lets the pipeline keep moving while one result waits;
// the input stalls only when both entries are full and the last stage holds a result.
// Configuration is written while no triangle is in flight; the user, not the core, ensures it.
module ray_triangle_intersect_core #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int IN_BITS   = 9 * COORD_BITS,
  localparam int IN_W      = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS  = 4 * COORD_BITS + 2 * FRAC_BITS + 3,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  // vertex0_x, vertex0_y, vertex0_z, vertex1_x .. vertex2_z, from bit 0 up
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_W-1:0]       s_axis_tdata,
  // hit, hit_distance, bary_u, bary_v, hit_point_x, hit_point_y, hit_point_z, from bit 0 up
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_W-1:0]      m_axis_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [2:0]            cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data
);
  import rti_pkg::*;

  localparam int NMUL    = 12;
  localparam int S_DIFF  = 1;
  localparam int S_CROSS = S_DIFF + MUL_LAT + 1;
  localparam int S_DOT   = S_CROSS + MUL_LAT + 2;
  localparam int S_DIVIN = S_DOT + 1;
  localparam int S_CHK   = S_DIVIN + DIV_LAT + 1;
  localparam int S_LAST  = S_CHK + MUL_LAT;

  localparam sword_t ONE    = sword_t'(1) <<< FRAC_BITS;
  localparam sword_t SHL_HI = SWORD_MAX >>> FRAC_BITS;
  localparam sword_t SHL_LO = -SHL_HI - sword_t'(1);
  localparam sword_t CRD_HI = (sword_t'(1) <<< (COORD_BITS - 1)) - sword_t'(1);
  localparam sword_t CRD_LO = -CRD_HI - sword_t'(1);

  // Widen a coordinate to the intermediate width.
  function automatic sword_t sext(logic [COORD_BITS-1:0] x);
    return {{(WORD_BITS-COORD_BITS){x[COORD_BITS-1]}}, x};
  endfunction

  // Shift left by the fraction width with saturation.
  function automatic sword_t sat_shl(sword_t x);
    if (x > SHL_HI) begin
      return SWORD_MAX;
    end
    if (x < SHL_LO) begin
      return SWORD_MIN;
    end
    return x <<< FRAC_BITS;
  endfunction

  // Clamp to the coordinate range.
  function automatic sword_t clamp_coord(sword_t x);
    if (x > CRD_HI) begin
      return CRD_HI;
    end
    if (x < CRD_LO) begin
      return CRD_LO;
    end
    return x;
  endfunction

  logic [COORD_BITS-1:0] org [0:2];
  logic [COORD_BITS-1:0] dir [0:2];
  logic [15:0]           eps;
  vec3_t                 ov;
  vec3_t                 dv;
  sword_t                eps_w;

  logic                  en;
  logic                  vld [1:S_LAST];
  logic                  in_xfer;
  sword_t                vin [0:8];

  vec3_t                 e1_s [S_DIFF:S_CROSS];
  vec3_t                 e2_s [S_DIFF:S_CROSS];
  vec3_t                 sv_s [S_DIFF:S_CROSS];
  sword_t                ma1 [0:NMUL-1];
  sword_t                mb1 [0:NMUL-1];
  sword_t                mp1 [0:NMUL-1];
  vec3_t                 hv;
  vec3_t                 qv;
  sword_t                ma2 [0:NMUL-1];
  sword_t                mb2 [0:NMUL-1];
  sword_t                mp2 [0:NMUL-1];
  sword_t                psum [0:3];
  sword_t                third [0:3];
  sword_t                dot [0:3];
  sword_t                a_div;
  sword_t                num_u;
  sword_t                num_v;
  sword_t                num_t;
  logic                  amiss [0:DIV_LAT];
  sword_t                uq;
  sword_t                vq;
  sword_t                tq;

  logic                  hit_c;
  logic signed [WORD_BITS:0] uv_sum;
  logic                  hit_s [0:MUL_LAT];
  sword_t                ts_s  [0:MUL_LAT];
  logic [FRAC_BITS:0]    u_s   [0:MUL_LAT];
  logic [FRAC_BITS:0]    v_s   [0:MUL_LAT];
  sword_t                mp3 [0:2];
  sword_t                hp [0:2];
  logic [OUT_BITS-1:0]   res;

  logic [1:0]            cnt;
  logic [OUT_BITS-1:0]   head;
  logic [OUT_BITS-1:0]   skid;
  logic                  push;
  logic                  pop;

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      org <= '{default: '0};
      dir <= '{default: '0};
      eps <= 16'd1;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ORG_X: org[0] <= cfg_data;
        REG_ORG_Y: org[1] <= cfg_data;
        REG_ORG_Z: org[2] <= cfg_data;
        REG_DIR_X: dir[0] <= cfg_data;
        REG_DIR_Y: dir[1] <= cfg_data;
        REG_DIR_Z: dir[2] <= cfg_data;
        REG_EPS:   eps    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign ov    = '{x: sext(org[0]), y: sext(org[1]), z: sext(org[2])};
  assign dv    = '{x: sext(dir[0]), y: sext(dir[1]), z: sext(dir[2])};
  assign eps_w = sword_t'(eps);

  // Pipeline advance: stall only when the last stage cannot hand over its result.
  assign en            = !(vld[S_LAST] && (cnt == 2'd2));
  assign s_axis_tready = en;
  assign in_xfer       = s_axis_tvalid && en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '{default: 1'b0};
    end else if (en) begin
      vld[1] <= in_xfer;
      for (int k = 2; k <= S_LAST; k++) begin
        vld[k] <= vld[k-1];
      end
    end
  end

  // Edges and origin offset.
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      vin[k] = sext(s_axis_tdata[k*COORD_BITS +: COORD_BITS]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e1_s[S_DIFF] <= '{x: sat_sub(vin[3], vin[0]), y: sat_sub(vin[4], vin[1]),
                        z: sat_sub(vin[5], vin[2])};
      e2_s[S_DIFF] <= '{x: sat_sub(vin[6], vin[0]), y: sat_sub(vin[7], vin[1]),
                        z: sat_sub(vin[8], vin[2])};
      sv_s[S_DIFF] <= '{x: sat_sub(ov.x, vin[0]), y: sat_sub(ov.y, vin[1]),
                        z: sat_sub(ov.z, vin[2])};
      for (int k = S_DIFF + 1; k <= S_CROSS; k++) begin
        e1_s[k] <= e1_s[k-1];
        e2_s[k] <= e2_s[k-1];
        sv_s[k] <= sv_s[k-1];
      end
    end
  end

  // Cross products h = dir x e2 and q = s x e1.
  always_comb begin
    ma1[0]  = dv.y;          mb1[0]  = e2_s[S_DIFF].z;
    ma1[1]  = dv.z;          mb1[1]  = e2_s[S_DIFF].y;
    ma1[2]  = dv.z;          mb1[2]  = e2_s[S_DIFF].x;
    ma1[3]  = dv.x;          mb1[3]  = e2_s[S_DIFF].z;
    ma1[4]  = dv.x;          mb1[4]  = e2_s[S_DIFF].y;
    ma1[5]  = dv.y;          mb1[5]  = e2_s[S_DIFF].x;
    ma1[6]  = sv_s[S_DIFF].y; mb1[6]  = e1_s[S_DIFF].z;
    ma1[7]  = sv_s[S_DIFF].z; mb1[7]  = e1_s[S_DIFF].y;
    ma1[8]  = sv_s[S_DIFF].z; mb1[8]  = e1_s[S_DIFF].x;
    ma1[9]  = sv_s[S_DIFF].x; mb1[9]  = e1_s[S_DIFF].z;
    ma1[10] = sv_s[S_DIFF].x; mb1[10] = e1_s[S_DIFF].y;
    ma1[11] = sv_s[S_DIFF].y; mb1[11] = e1_s[S_DIFF].x;
  end

  for (genvar g = 0; g < NMUL; g++) begin : g_mul1
    rti_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (ma1[g]),
      .b   (mb1[g]),
      .p   (mp1[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hv <= '{x: sat_sub(mp1[0], mp1[1]), y: sat_sub(mp1[2], mp1[3]),
              z: sat_sub(mp1[4], mp1[5])};
      qv <= '{x: sat_sub(mp1[6], mp1[7]), y: sat_sub(mp1[8], mp1[9]),
              z: sat_sub(mp1[10], mp1[11])};
    end
  end

  // Dot products: e1.h, s.h, dir.q and e2.q.
  always_comb begin
    ma2[0]  = e1_s[S_CROSS].x; mb2[0]  = hv.x;
    ma2[1]  = e1_s[S_CROSS].y; mb2[1]  = hv.y;
    ma2[2]  = e1_s[S_CROSS].z; mb2[2]  = hv.z;
    ma2[3]  = sv_s[S_CROSS].x; mb2[3]  = hv.x;
    ma2[4]  = sv_s[S_CROSS].y; mb2[4]  = hv.y;
    ma2[5]  = sv_s[S_CROSS].z; mb2[5]  = hv.z;
    ma2[6]  = dv.x;            mb2[6]  = qv.x;
    ma2[7]  = dv.y;            mb2[7]  = qv.y;
    ma2[8]  = dv.z;            mb2[8]  = qv.z;
    ma2[9]  = e2_s[S_CROSS].x; mb2[9]  = qv.x;
    ma2[10] = e2_s[S_CROSS].y; mb2[10] = qv.y;
    ma2[11] = e2_s[S_CROSS].z; mb2[11] = qv.z;
  end

  for (genvar g = 0; g < NMUL; g++) begin : g_mul2
    rti_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clk (clk),
      .en  (en),
      .a   (ma2[g]),
      .b   (mb2[g]),
      .p   (mp2[g])
    );
  end

  // Two-level sums, then the numerators and the determinant test.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        psum[k]  <= sat_add(mp2[3*k], mp2[3*k+1]);
        third[k] <= mp2[3*k+2];
        dot[k]   <= sat_add(psum[k], third[k]);
      end
      a_div    <= dot[0];
      num_u    <= sat_shl(dot[1]);
      num_v    <= sat_shl(dot[2]);
      num_t    <= sat_shl(dot[3]);
      amiss[0] <= (dot[0] == '0) || ((dot[0] > -eps_w) && (dot[0] < eps_w));
      for (int k = 1; k <= DIV_LAT; k++) begin
        amiss[k] <= amiss[k-1];
      end
    end
  end

  rti_div u_div_u (.clk(clk), .en(en), .n(num_u), .d(a_div), .q(uq));
  rti_div u_div_v (.clk(clk), .en(en), .n(num_v), .d(a_div), .q(vq));
  rti_div u_div_t (.clk(clk), .en(en), .n(num_t), .d(a_div), .q(tq));

  // Range tests on u, v and t; everything is zeroed on a miss.
  assign uv_sum = {uq[WORD_BITS-1], uq} + {vq[WORD_BITS-1], vq};
  assign hit_c  = !amiss[DIV_LAT]
               && !(uq < 0) && !(uq > ONE)
               && !(vq < 0) && !(uv_sum > (WORD_BITS+1)'(ONE))
               && (tq > eps_w);

  always_ff @(posedge clk) begin
    if (en) begin
      hit_s[0] <= hit_c;
      ts_s[0]  <= hit_c ? clamp_coord(tq) : '0;
      u_s[0]   <= hit_c ? uq[FRAC_BITS:0] : '0;
      v_s[0]   <= hit_c ? vq[FRAC_BITS:0] : '0;
      for (int k = 1; k <= MUL_LAT; k++) begin
        hit_s[k] <= hit_s[k-1];
        ts_s[k]  <= ts_s[k-1];
        u_s[k]   <= u_s[k-1];
        v_s[k]   <= v_s[k-1];
      end
    end
  end

  // Hit point = origin + dir * t.
  rti_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_px (.clk(clk), .en(en), .a(dv.x), .b(ts_s[0]),
                                             .p(mp3[0]));
  rti_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_py (.clk(clk), .en(en), .a(dv.y), .b(ts_s[0]),
                                             .p(mp3[1]));
  rti_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_pz (.clk(clk), .en(en), .a(dv.z), .b(ts_s[0]),
                                             .p(mp3[2]));

  assign hp[0] = hit_s[MUL_LAT] ? clamp_coord(sat_add(ov.x, mp3[0])) : '0;
  assign hp[1] = hit_s[MUL_LAT] ? clamp_coord(sat_add(ov.y, mp3[1])) : '0;
  assign hp[2] = hit_s[MUL_LAT] ? clamp_coord(sat_add(ov.z, mp3[2])) : '0;

  assign res = {hp[2][COORD_BITS-1:0], hp[1][COORD_BITS-1:0], hp[0][COORD_BITS-1:0],
                v_s[MUL_LAT], u_s[MUL_LAT], ts_s[MUL_LAT][COORD_BITS-1:0],
                hit_s[MUL_LAT]};

  // Two-entry output buffer.
  assign push = vld[S_LAST] && en;
  assign pop  = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else begin
      unique case (cnt)
        2'd0: cnt <= push ? 2'd1 : 2'd0;
        2'd1: cnt <= (push && !pop) ? 2'd2 : ((pop && !push) ? 2'd0 : 2'd1);
        2'd2: cnt <= pop ? 2'd1 : 2'd2;
        default: cnt <= 2'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cnt == 2'd2) begin
      if (pop) begin
        head <= skid;
      end
    end else if (push) begin
      if (cnt == 2'd0 || pop) begin
        head <= res;
      end else begin
        skid <= res;
      end
    end
  end

  assign m_axis_tvalid = (cnt != 2'd0);
  assign m_axis_tdata  = OUT_W'(head);

endmodule

FILE: hw/rtl/rti_checker.sv
// Port-level checks on the result stream of the intersection core, bound to the top level.
module rti_checker #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int OUT_BITS  = 4 * COORD_BITS + 2 * FRAC_BITS + 3,
  localparam int OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input logic             clk,
  input logic             rst,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  localparam int U_LO = 1 + COORD_BITS;
  localparam int V_LO = U_LO + FRAC_BITS + 1;

  // A stalled transfer keeps its result.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A miss reports every field as zero.
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[OUT_W-1:1] == '0))
    else $error("miss with non-zero fields");

  // A hit lies in front of the origin.
  a_hit_front: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |->
      !m_axis_tdata[COORD_BITS] && (m_axis_tdata[COORD_BITS:1] != '0))
    else $error("hit with non-positive distance");

  // Barycentrics of a hit stay within the triangle.
  a_hit_bary: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[0] |->
      ((FRAC_BITS+2)'(m_axis_tdata[U_LO +: FRAC_BITS+1])
       + (FRAC_BITS+2)'(m_axis_tdata[V_LO +: FRAC_BITS+1]))
      <= ((FRAC_BITS+2)'(1) << FRAC_BITS))
    else $error("barycentrics out of range");

endmodule

bind ray_triangle_intersect_core rti_checker #(
  .COORD_BITS (COORD_BITS),
  .FRAC_BITS  (FRAC_BITS)
) u_rti_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/tb.sv
// Self-checking testbench for the ray/triangle intersection core.
`timescale 1ns / 100ps

module tb;
  import rti_pkg::*;

  localparam int CB = 32;
  localparam int FB = 16;
  localparam int IN_W = 288;
  localparam int OUT_W = 168;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 120;

  typedef logic signed [CB-1:0] coord_t;
  typedef logic signed [127:0] wide_t;
  typedef coord_t tri_t [9];

  typedef struct {
    logic       hit;
    coord_t     distance;
    logic [FB:0] u;
    logic [FB:0] v;
    coord_t     px;
    coord_t     py;
    coord_t     pz;
  } isect_t;

  // Holds a copy of the ray and the expected intersection results.
  class isect_scoreboard;
    vec3_t   org;
    vec3_t   dir;
    sword_t  eps;
    isect_t  pending_hits[$];
    int      errors;

    function new();
      org = '0;
      dir = '0;
      eps = 1;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CB-1:0] val);
      case (idx)
        REG_ORG_X: org.x = sword_t'(coord_t'(val));
        REG_ORG_Y: org.y = sword_t'(coord_t'(val));
        REG_ORG_Z: org.z = sword_t'(coord_t'(val));
        REG_DIR_X: dir.x = sword_t'(coord_t'(val));
        REG_DIR_Y: dir.y = sword_t'(coord_t'(val));
        REG_DIR_Z: dir.z = sword_t'(coord_t'(val));
        REG_EPS:   eps = sword_t'({1'b0, val[15:0]});
        default: ;
      endcase
    endfunction

    // Saturate an exact value to the 64-bit working range.
    function sword_t clip(wide_t x);
      wide_t hi;
      wide_t lo;
      hi = SWORD_MAX;
      lo = SWORD_MIN;
      if (x > hi) return SWORD_MAX;
      if (x < lo) return SWORD_MIN;
      return x[63:0];
    endfunction

    function coord_t clamp32(sword_t x);
      if (x > 64'sh7fffffff) return 32'h7fffffff;
      if (x < -64'sh80000000) return 32'h80000000;
      return x[31:0];
    endfunction

    function sword_t add(sword_t a, sword_t b);
      wide_t wa;
      wide_t wb;
      wa = a;
      wb = b;
      return clip(wa + wb);
    endfunction

    function sword_t sub(sword_t a, sword_t b);
      wide_t wa;
      wide_t wb;
      wa = a;
      wb = b;
      return clip(wa - wb);
    endfunction

    // Exact product rescaled by an arithmetic shift, i.e. floor division.
    function sword_t mulq(sword_t a, sword_t b);
      wide_t wa;
      wide_t wb;
      wide_t p;
      wa = a;
      wb = b;
      p = wa * wb;
      return clip(p >>> FB);
    endfunction

    function sword_t shl_div(sword_t n, sword_t d);
      wide_t wn;
      wide_t wd;
      wn = clip(wide_t'(n) <<< FB);
      wd = d;
      return clip(wn / wd);
    endfunction

    function vec3_t vsub(vec3_t a, vec3_t b);
      vec3_t r;
      r.x = sub(a.x, b.x);
      r.y = sub(a.y, b.y);
      r.z = sub(a.z, b.z);
      return r;
    endfunction

    function vec3_t vcross(vec3_t a, vec3_t b);
      vec3_t r;
      r.x = sub(mulq(a.y, b.z), mulq(a.z, b.y));
      r.y = sub(mulq(a.z, b.x), mulq(a.x, b.z));
      r.z = sub(mulq(a.x, b.y), mulq(a.y, b.x));
      return r;
    endfunction

    function sword_t dot(vec3_t a, vec3_t b);
      return add(add(mulq(a.x, b.x), mulq(a.y, b.y)), mulq(a.z, b.z));
    endfunction

    // Moller-Trumbore test of the held ray against one triangle.
    function isect_t predict(tri_t tv);
      isect_t r;
      vec3_t  v0, v1, v2, e1, e2, h, s, q;
      sword_t det, u, v, t;
      coord_t ts;
      wide_t  uv;
      r = '{default: '0};
      v0 = '{sword_t'(tv[0]), sword_t'(tv[1]), sword_t'(tv[2])};
      v1 = '{sword_t'(tv[3]), sword_t'(tv[4]), sword_t'(tv[5])};
      v2 = '{sword_t'(tv[6]), sword_t'(tv[7]), sword_t'(tv[8])};
      e1 = vsub(v1, v0);
      e2 = vsub(v2, v0);
      h = vcross(dir, e2);
      det = dot(e1, h);
      if (det == 0 || (det > -eps && det < eps)) return r;
      s = vsub(org, v0);
      u = shl_div(dot(s, h), det);
      if (u < 0 || u > (64'sd1 <<< FB)) return r;
      q = vcross(s, e1);
      v = shl_div(dot(dir, q), det);
      uv = wide_t'(u) + wide_t'(v);
      if (v < 0 || uv > (128'sd1 <<< FB)) return r;
      t = shl_div(dot(e2, q), det);
      if (t <= eps) return r;
      ts = clamp32(t);
      r.hit = 1'b1;
      r.distance = ts;
      r.u = u[FB:0];
      r.v = v[FB:0];
      r.px = clamp32(add(org.x, mulq(dir.x, sword_t'(ts))));
      r.py = clamp32(add(org.y, mulq(dir.y, sword_t'(ts))));
      r.pz = clamp32(add(org.z, mulq(dir.z, sword_t'(ts))));
      return r;
    endfunction

    function void note_triangle(tri_t tv);
      pending_hits.push_back(predict(tv));
    endfunction

    function void field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
        $error("%s mismatch: expected %h, got %h", name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_W-1:0] d);
      isect_t e;
      if (pending_hits.size() == 0) begin
        $error("result transfer with no triangle outstanding: %h", d);
        errors++;
        return;
      end
      e = pending_hits.pop_front();
      field("hit", e.hit, d[0]);
      field("hit_distance", $unsigned(e.distance), d[32:1]);
      field("bary_u", e.u, d[49:33]);
      field("bary_v", e.v, d[66:50]);
      field("hit_point_x", $unsigned(e.px), d[98:67]);
      field("hit_point_y", $unsigned(e.py), d[130:99]);
      field("hit_point_z", $unsigned(e.pz), d[162:131]);
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [IN_W-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OUT_W-1:0]  m_axis_tdata;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [CB-1:0]     cfg_data = '0;

  isect_scoreboard sb = new();
  bit     pressure_arm = 1'b0;
  int     idle_cycles = 0;
  coord_t ray_o [3];
  coord_t ray_d [3];

  always #5 clk = ~clk;

  ray_triangle_intersect_core DUT (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready) || rst) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result checking on every output transfer.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tdata);
    end
  end

  // Receiver: segments of steady, random or sparse readiness, plus one long hold-off.
  initial begin
    int mode;
    int len;
    bit held;
    held = 1'b0;
    @(negedge clk);
    forever begin
      if (pressure_arm && !held) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      mode = $urandom_range(0, 2);
      len = $urandom_range(10, 150);
      repeat (len) begin
        case (mode)
          0: m_axis_tready <= 1'b1;
          1: m_axis_tready <= $urandom_range(0, 1);
          default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(negedge clk);
      end
    end
  end

  // Offer one triangle and hold it until the transfer; valid stays high afterwards.
  task automatic send_tri(tri_t tv);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    for (int k = 0; k < 9; k++) s_axis_tdata[32*k +: 32] <= tv[k];
    do @(posedge clk); while (!s_axis_tready);
    sb.note_triangle(tv);
  endtask

  task automatic pause_input(int n);
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CB-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // Wait for every outstanding result, then for the pipeline to empty.
  task automatic drain();
    pause_input(1);
    while (sb.pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Load a new ray and tolerance while the core is idle.
  task automatic set_ray(coord_t o0, coord_t o1, coord_t o2,
                         coord_t d0, coord_t d1, coord_t d2, logic [15:0] eps);
    drain();
    ray_o = '{o0, o1, o2};
    ray_d = '{d0, d1, d2};
    write_reg(REG_ORG_X, o0);
    write_reg(REG_ORG_Y, o1);
    write_reg(REG_ORG_Z, o2);
    write_reg(REG_DIR_X, d0);
    write_reg(REG_DIR_Y, d1);
    write_reg(REG_DIR_Z, d2);
    write_reg(REG_EPS, {16'($urandom), eps});
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Triangle built around a point on the ray, so that most of them are struck.
  function automatic tri_t aimed_tri();
    tri_t   tv;
    sword_t t, a, b, e1, e2, p;
    t = $urandom_range(32'h100, 32'h100000);
    a = $urandom_range(0, 49152);
    b = $urandom_range(0, 49152);
    if ($urandom_range(0, 9) == 0) t = -t;
    for (int k = 0; k < 3; k++) begin
      e1 = $signed($urandom_range(0, 32'h100000)) - 64'sh80000;
      e2 = $signed($urandom_range(0, 32'h100000)) - 64'sh80000;
      p = sword_t'(ray_o[k]) + ((sword_t'(ray_d[k]) * t) >>> FB);
      p = p - ((a * e1) >>> FB) - ((b * e2) >>> FB);
      tv[k] = p[31:0];
      tv[3+k] = p[31:0] + e1[31:0];
      tv[6+k] = p[31:0] + e2[31:0];
    end
    return tv;
  endfunction

  function automatic tri_t plane_tri(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                     coord_t x2, coord_t y2, coord_t z);
    tri_t tv;
    tv = '{x0, y0, z, x1, y1, z, x2, y2, z};
    return tv;
  endfunction

  localparam coord_t ONE = 32'sh10000;

  initial begin
    tri_t tv;
    int   burst;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset ray: zero direction gives a zero determinant throughout.
    send_tri('{default: 32'h0});
    send_tri('{default: 32'h7fffffff});
    send_tri('{default: 32'h80000000});

    // Ray along +z from the origin against triangles in planes of constant z.
    set_ray(0, 0, 0, 0, 0, ONE, 16'd1);
    send_tri(plane_tri(-ONE, -ONE, 3*ONE, -ONE, -ONE, 3*ONE, 5*ONE));
    send_tri(plane_tri(0, 0, ONE, 0, 0, ONE, 5*ONE));
    send_tri(plane_tri(ONE, 0, 0, 0, 0, ONE, 5*ONE));
    send_tri(plane_tri(-ONE, -ONE, 3*ONE, -ONE, -ONE, 3*ONE, -5*ONE));
    send_tri(plane_tri(ONE, ONE, 3*ONE, ONE, ONE, 3*ONE, 5*ONE));
    send_tri(plane_tri(-ONE, -ONE, 3*ONE, -ONE, -ONE, 3*ONE, 0));
    send_tri(plane_tri(-ONE, -ONE, 3*ONE, -ONE, -ONE, 3*ONE, 1));
    send_tri('{0, 0, 0, ONE, 0, 0, 0, 0, ONE});
    send_tri('{default: 32'haaaaaaaa});
    send_tri('{default: 32'h55555555});
    send_tri('{32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 32'h80000000,
               32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff});

    // Tiny direction and zero tolerance: saturated distance and parallel triangles.
    set_ray(ONE, -ONE, 0, 0, 0, 1, 16'd0);
    send_tri(plane_tri(-4*ONE, -4*ONE, 8*ONE, -4*ONE, -4*ONE, 8*ONE, 1000*ONE));
    send_tri(plane_tri(-4*ONE, -4*ONE, 8*ONE, -4*ONE, -4*ONE, 8*ONE, 2));
    send_tri('{0, 0, 0, ONE, 0, 0, 0, 0, ONE});
    send_tri(plane_tri(0, 0, 0, 0, 0, 0, ONE));

    // Random phases, each with its own ray and tolerance.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_ray(0, 0, 0, ONE, ONE, ONE, 16'd1);
        1: set_ray(32'($urandom), 32'($urandom), 32'($urandom),
                   32'($urandom), 32'($urandom), 32'($urandom), 16'($urandom));
        2: set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff,
                   32'h80000000, 32'h7fffffff, 32'h80000000, 16'hffff);
        default: set_ray($signed($urandom_range(0, 32'h200000)) - 32'sh100000,
                         $signed($urandom_range(0, 32'h200000)) - 32'sh100000,
                         $signed($urandom_range(0, 32'h200000)) - 32'sh100000,
                         $signed($urandom_range(0, 32'h80000)) - 32'sh40000,
                         $signed($urandom_range(0, 32'h80000)) - 32'sh40000,
                         $signed($urandom_range(0, 32'h80000)) - 32'sh40000,
                         (ph == 4) ? 16'hffff : 16'($urandom_range(0, 64)));
      endcase
      if (ph == 3) pressure_arm = 1'b1;
      for (int n = 0; n < 100; n += burst) begin
        burst = $urandom_range(1, 20);
        for (int b = 0; b < burst; b++) begin
          case ($urandom_range(0, 9))
            0: for (int k = 0; k < 9; k++) tv[k] = 32'($urandom);
            1: begin
              tv = aimed_tri();
              tv[$urandom_range(0, 8)] = 32'($urandom);
            end
            default: tv = aimed_tri();
          endcase
          send_tri(tv);
        end
        if ($urandom_range(0, 2) != 0) pause_input($urandom_range(1, 12));
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/rti_pkg.sv
hw/rtl/rti_mul.sv
hw/rtl/rti_div.sv
hw/rtl/ray_triangle_intersect_core.sv
hw/rtl/rti_checker.sv
verif/tb.sv
